### rtl/cct_pkg.sv
// Shared types for the circle versus capsule overlap test.
// Used by cct_region, cct_wide and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cct_pkg;

    // Which end of the segment is closest, and the end-point hit results.
    typedef struct packed {
        logic use_start;
        logic use_end;
        logic hit_start;
        logic hit_end;
    } region_t;

endpackage

`default_nettype wire

### rtl/cct_geom.sv
// Front of the pipeline: coordinate differences, products and sums.
// Three register stages; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module cct_geom #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            en,
    input  wire logic signed [COORD_WIDTH-1:0]   circle_x,
    input  wire logic signed [COORD_WIDTH-1:0]   circle_y,
    input  wire logic        [COORD_WIDTH-2:0]   circle_radius,
    input  wire logic signed [COORD_WIDTH-1:0]   seg_start_x,
    input  wire logic signed [COORD_WIDTH-1:0]   seg_start_y,
    input  wire logic signed [COORD_WIDTH-1:0]   seg_end_x,
    input  wire logic signed [COORD_WIDTH-1:0]   seg_end_y,
    input  wire logic        [COORD_WIDTH-2:0]   capsule_radius,
    output logic signed      [2*COORD_WIDTH+2:0] proj_out,
    output logic             [2*COORD_WIDTH+1:0] len2_out,
    output logic             [2*COORD_WIDTH+1:0] d2_start_out,
    output logic             [2*COORD_WIDTH+1:0] d2_end_out,
    output logic signed      [2*COORD_WIDTH+2:0] cross_out,
    output logic             [2*COORD_WIDTH-1:0] r2_out
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 2 * W + 2;
    localparam int SW = 2 * W + 3;
    localparam int UW = 2 * W + 2;

    // Stage 1: differences and radius sum.
    logic signed [DW-1:0] dx_reg, dy_reg, bx_reg, by_reg, ex_reg, ey_reg;
    logic        [W-1:0]  rs_reg;

    // Stage 2: products.
    logic signed [PW-1:0] dxbx_reg, dyby_reg, bxbx_reg, byby_reg;
    logic signed [PW-1:0] dxdx_reg, dydy_reg, exex_reg, eyey_reg;
    logic signed [PW-1:0] dxby_reg, dybx_reg;
    logic        [2*W-1:0] r2_reg;

    // Stage 3: sums.
    logic signed [SW-1:0]  proj_reg, cross_reg;
    logic        [UW-1:0]  len2_reg, d2s_reg, d2e_reg;
    logic        [2*W-1:0] r2_s3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg <= DW'(circle_x) - DW'(seg_start_x);
            dy_reg <= DW'(circle_y) - DW'(seg_start_y);
            bx_reg <= DW'(seg_end_x) - DW'(seg_start_x);
            by_reg <= DW'(seg_end_y) - DW'(seg_start_y);
            ex_reg <= DW'(circle_x) - DW'(seg_end_x);
            ey_reg <= DW'(circle_y) - DW'(seg_end_y);
            rs_reg <= W'(circle_radius) + W'(capsule_radius);

            dxbx_reg <= PW'(dx_reg) * PW'(bx_reg);
            dyby_reg <= PW'(dy_reg) * PW'(by_reg);
            bxbx_reg <= PW'(bx_reg) * PW'(bx_reg);
            byby_reg <= PW'(by_reg) * PW'(by_reg);
            dxdx_reg <= PW'(dx_reg) * PW'(dx_reg);
            dydy_reg <= PW'(dy_reg) * PW'(dy_reg);
            exex_reg <= PW'(ex_reg) * PW'(ex_reg);
            eyey_reg <= PW'(ey_reg) * PW'(ey_reg);
            dxby_reg <= PW'(dx_reg) * PW'(by_reg);
            dybx_reg <= PW'(dy_reg) * PW'(bx_reg);
            r2_reg   <= (2*W)'(rs_reg) * (2*W)'(rs_reg);

            // Squares are never negative and stay below 2^(2W+1).
            proj_reg  <= SW'(dxbx_reg) + SW'(dyby_reg);
            cross_reg <= SW'(dxby_reg) - SW'(dybx_reg);
            len2_reg  <= UW'(bxbx_reg[2*W:0]) + UW'(byby_reg[2*W:0]);
            d2s_reg   <= UW'(dxdx_reg[2*W:0]) + UW'(dydy_reg[2*W:0]);
            d2e_reg   <= UW'(exex_reg[2*W:0]) + UW'(eyey_reg[2*W:0]);
            r2_s3_reg <= r2_reg;
        end
    end

    assign proj_out     = proj_reg;
    assign len2_out     = len2_reg;
    assign d2_start_out = d2s_reg;
    assign d2_end_out   = d2e_reg;
    assign cross_out    = cross_reg;
    assign r2_out       = r2_s3_reg;

endmodule

`default_nettype wire

### rtl/cct_region.sv
// Region decision: clamps the projection, tests both end points and
// takes the magnitude of the cross product. Depends on cct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cct_region #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            en,
    input  wire logic signed [2*COORD_WIDTH+2:0] proj_in,
    input  wire logic        [2*COORD_WIDTH+1:0] len2_in,
    input  wire logic        [2*COORD_WIDTH+1:0] d2_start_in,
    input  wire logic        [2*COORD_WIDTH+1:0] d2_end_in,
    input  wire logic signed [2*COORD_WIDTH+2:0] cross_in,
    input  wire logic        [2*COORD_WIDTH-1:0] r2_in,
    output cct_pkg::region_t                     region_out,
    output logic             [2*COORD_WIDTH+1:0] cross_mag_out,
    output logic             [2*COORD_WIDTH+1:0] len2_out,
    output logic             [2*COORD_WIDTH-1:0] r2_out
);

    localparam int W  = COORD_WIDTH;
    localparam int SW = 2 * W + 3;
    localparam int UW = 2 * W + 2;

    cct_pkg::region_t  region_reg, region_next;
    logic [UW-1:0]     mag_reg, len2_reg;
    logic [2*W-1:0]    r2_reg;
    logic [SW-1:0]     cross_abs;

    always_comb begin
        region_next.use_start = (proj_in <= SW'(0));
        region_next.use_end   = (proj_in >= $signed({1'b0, len2_in}));
        region_next.hit_start = (d2_start_in < UW'(r2_in));
        region_next.hit_end   = (d2_end_in < UW'(r2_in));
    end

    // The most negative cross product still fits once negated.
    assign cross_abs = cross_in[SW-1] ? SW'(-cross_in) : SW'(cross_in);

    always_ff @(posedge aclk) begin
        if (en) begin
            region_reg <= region_next;
            mag_reg    <= cross_abs[UW-1:0];
            len2_reg   <= len2_in;
            r2_reg     <= r2_in;
        end
    end

    assign region_out    = region_reg;
    assign cross_mag_out = mag_reg;
    assign len2_out      = len2_reg;
    assign r2_out        = r2_reg;

endmodule

`default_nettype wire

### rtl/cct_wide.sv
// Wide comparison cross^2 < R^2 * L built from split partial products,
// and the final hit selection. Depends on cct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cct_wide #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  cct_pkg::region_t                 region_in,
    input  wire logic    [2*COORD_WIDTH+1:0] cross_mag_in,
    input  wire logic    [2*COORD_WIDTH+1:0] len2_in,
    input  wire logic    [2*COORD_WIDTH-1:0] r2_in,
    output logic                             hit_out
);

    localparam int W  = COORD_WIDTH;
    localparam int H  = W + 1;          // split point of each wide operand
    localparam int PP = 2 * H;          // width of a half-by-half product
    localparam int LW = 4 * W + 4;      // width of both sides of the compare

    logic [H-1:0]   cr_hi, cr_lo, ln_hi, ln_lo, r2_lo;
    logic [W-2:0]   r2_hi;

    // Stage 5: partial products.
    logic [PP-1:0]  chh_reg, chl_reg, cll_reg;
    logic [PP-1:0]  rhh_reg, rhl_reg, rlh_reg, rll_reg;
    cct_pkg::region_t region_s5_reg;

    // Stage 6: both sides assembled.
    logic [LW-1:0]  lhs_reg, rhs_reg;
    cct_pkg::region_t region_s6_reg;

    logic           hit_reg, hit_next;

    assign cr_hi = cross_mag_in[2*H-1:H];
    assign cr_lo = cross_mag_in[H-1:0];
    assign ln_hi = len2_in[2*H-1:H];
    assign ln_lo = len2_in[H-1:0];
    assign r2_hi = r2_in[2*W-1:H];
    assign r2_lo = r2_in[H-1:0];

    always_comb begin
        if (region_s6_reg.use_start) begin
            hit_next = region_s6_reg.hit_start;
        end else if (region_s6_reg.use_end) begin
            hit_next = region_s6_reg.hit_end;
        end else begin
            hit_next = (lhs_reg < rhs_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            chh_reg <= PP'(cr_hi) * PP'(cr_hi);
            chl_reg <= PP'(cr_hi) * PP'(cr_lo);
            cll_reg <= PP'(cr_lo) * PP'(cr_lo);
            rhh_reg <= PP'(r2_hi) * PP'(ln_hi);
            rhl_reg <= PP'(r2_hi) * PP'(ln_lo);
            rlh_reg <= PP'(r2_lo) * PP'(ln_hi);
            rll_reg <= PP'(r2_lo) * PP'(ln_lo);
            region_s5_reg <= region_in;

            // The cross term of a square appears twice, hence the extra shift.
            lhs_reg <= (LW'(chh_reg) << (2*H)) + (LW'(chl_reg) << (H+1)) + LW'(cll_reg);
            rhs_reg <= (LW'(rhh_reg) << (2*H)) + ((LW'(rhl_reg) + LW'(rlh_reg)) << H)
                       + LW'(rll_reg);
            region_s6_reg <= region_s5_reg;

            hit_reg <= hit_next;
        end
    end

    assign hit_out = hit_reg;

endmodule

`default_nettype wire

### rtl/circle_capsule_overlap_test.sv
// Top level of the circle versus capsule overlap test: stream ports,
// valid pipeline and stall control. Depends on cct_pkg, cct_geom,
// cct_region and cct_wide.
//
//   channel   direction  item                        tdata bits (W = 16)
//   s_axis    in         one query                   128 (126 used)
//   m_axis    out        one hit flag per query      8 (1 used)
//
// Each item passes seven register stages: three for differences, products
// and sums, one for the region decision, three for the split wide multiply
// and the final compare. A new item may enter in every cycle in which no
// result is held. The whole pipeline holds while a result waits on
// m_axis_tready; reset clears only the valid bits and keeps s_axis_tready
// low.
`timescale 1ns / 1ps
`default_nettype none

module circle_capsule_overlap_test #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,

    input  wire logic   s_axis_tvalid,
    output logic        s_axis_tready,
    // From bit 0 up: circle_x, circle_y, circle_radius, seg_start_x,
    // seg_start_y, seg_end_x, seg_end_y, capsule_radius, zero fill.
    input  wire logic [((8*COORD_WIDTH-2+7)/8)*8-1:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  wire logic   m_axis_tready,
    // From bit 0 up: hit, zero fill.
    output logic [7:0]  m_axis_tdata
);

    localparam int W      = COORD_WIDTH;
    localparam int NSTAGE = 7;
    localparam int OFF_CY = W;
    localparam int OFF_RC = 2 * W;
    localparam int OFF_AX = 3 * W - 1;
    localparam int OFF_AY = 4 * W - 1;
    localparam int OFF_BX = 5 * W - 1;
    localparam int OFF_BY = 6 * W - 1;
    localparam int OFF_RK = 7 * W - 1;

    logic [NSTAGE-1:0]     valid_reg, valid_next;
    logic                  adv;

    logic signed [2*W+2:0] proj_s3, cross_s3;
    logic        [2*W+1:0] len2_s3, d2s_s3, d2e_s3;
    logic        [2*W-1:0] r2_s3;
    cct_pkg::region_t      region_s4;
    logic        [2*W+1:0] mag_s4, len2_s4;
    logic        [2*W-1:0] r2_s4;
    logic                  hit;

    // Everything moves together unless a finished result is held.
    assign adv           = !valid_reg[NSTAGE-1] || m_axis_tready;
    assign s_axis_tready = aresetn && adv;
    assign valid_next    = {valid_reg[NSTAGE-2:0], s_axis_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    cct_geom #(
        .COORD_WIDTH(W)
    ) u_geom (
        .aclk          (aclk),
        .en            (adv),
        .circle_x      ($signed(s_axis_tdata[0 +: W])),
        .circle_y      ($signed(s_axis_tdata[OFF_CY +: W])),
        .circle_radius (s_axis_tdata[OFF_RC +: W-1]),
        .seg_start_x   ($signed(s_axis_tdata[OFF_AX +: W])),
        .seg_start_y   ($signed(s_axis_tdata[OFF_AY +: W])),
        .seg_end_x     ($signed(s_axis_tdata[OFF_BX +: W])),
        .seg_end_y     ($signed(s_axis_tdata[OFF_BY +: W])),
        .capsule_radius(s_axis_tdata[OFF_RK +: W-1]),
        .proj_out      (proj_s3),
        .len2_out      (len2_s3),
        .d2_start_out  (d2s_s3),
        .d2_end_out    (d2e_s3),
        .cross_out     (cross_s3),
        .r2_out        (r2_s3)
    );

    cct_region #(
        .COORD_WIDTH(W)
    ) u_region (
        .aclk         (aclk),
        .en           (adv),
        .proj_in      (proj_s3),
        .len2_in      (len2_s3),
        .d2_start_in  (d2s_s3),
        .d2_end_in    (d2e_s3),
        .cross_in     (cross_s3),
        .r2_in        (r2_s3),
        .region_out   (region_s4),
        .cross_mag_out(mag_s4),
        .len2_out     (len2_s4),
        .r2_out       (r2_s4)
    );

    cct_wide #(
        .COORD_WIDTH(W)
    ) u_wide (
        .aclk        (aclk),
        .en          (adv),
        .region_in   (region_s4),
        .cross_mag_in(mag_s4),
        .len2_in     (len2_s4),
        .r2_in       (r2_s4),
        .hit_out     (hit)
    );

    assign m_axis_tvalid = valid_reg[NSTAGE-1];
    assign m_axis_tdata  = {7'b0000000, hit};

`ifndef NO_ASSERTIONS
    // A held result freezes every stage of the pipeline.
    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |=> $stable(valid_reg))
        else $error("pipeline valid bits moved during a stall");

    // An accepted item always occupies the first stage next cycle.
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> valid_reg[0])
        else $error("accepted item missing from first stage");

    // Items in the middle of the pipe advance and are never dropped.
    a_mid_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready && valid_reg[3] |=> valid_reg[4])
        else $error("item lost between region and wide stages");
`endif

endmodule

`default_nettype wire

### tb/sv/circle_capsule_overlap_test_tb.sv
// Testbench for circle_capsule_overlap_test: drives queries on s_axis and checks
// each hit flag on m_axis against an exact integer predictor.
// Depends only on the RTL of the block.
`timescale 1ns / 1ps

module circle_capsule_overlap_test_tb;

    localparam int COORD_W     = 16;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 20;

    // One query as the block sees it, with fields at their port widths.
    typedef struct {
        logic signed [COORD_W-1:0] circle_x;
        logic signed [COORD_W-1:0] circle_y;
        logic        [COORD_W-2:0] circle_radius;
        logic signed [COORD_W-1:0] seg_start_x;
        logic signed [COORD_W-1:0] seg_start_y;
        logic signed [COORD_W-1:0] seg_end_x;
        logic signed [COORD_W-1:0] seg_end_y;
        logic        [COORD_W-2:0] capsule_radius;
    } query_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // From bit 0 up: circle_x, circle_y, circle_radius, seg_start_x,
    // seg_start_y, seg_end_x, seg_end_y, capsule_radius, zero fill.
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // From bit 0 up: hit, zero fill.
    logic [7:0]   m_axis_tdata;

    bit pending_hits[$];
    int mismatch_count = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit tx_gaps = 1'b1;
    bit rx_stalls = 1'b1;

    circle_capsule_overlap_test #(.COORD_WIDTH(COORD_W)) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    // Exact hit test: clamp the projection of the centre onto the segment and
    // compare squared distance with the squared radius sum, cross-multiplied.
    function automatic bit predict_hit(query_t q);
        longint cx, cy, ax, ay, ex, ey, dx, dy, bx, by;
        longint proj, len2, dist2, cross_prod, rsum, rsum2;
        logic [127:0] lhs, rhs;
        cx = longint'(q.circle_x);
        cy = longint'(q.circle_y);
        ax = longint'(q.seg_start_x);
        ay = longint'(q.seg_start_y);
        ex = longint'(q.seg_end_x);
        ey = longint'(q.seg_end_y);
        rsum = longint'(q.circle_radius) + longint'(q.capsule_radius);
        rsum2 = rsum * rsum;
        dx = cx - ax;
        dy = cy - ay;
        bx = ex - ax;
        by = ey - ay;
        proj = dx * bx + dy * by;
        len2 = bx * bx + by * by;
        if (proj <= 0) begin
            dist2 = dx * dx + dy * dy;
            return dist2 < rsum2;
        end
        if (proj >= len2) begin
            dist2 = (cx - ex) * (cx - ex) + (cy - ey) * (cy - ey);
            return dist2 < rsum2;
        end
        cross_prod = dx * by - dy * bx;
        if (cross_prod < 0) begin
            cross_prod = -cross_prod;
        end
        lhs = 128'(cross_prod) * 128'(cross_prod);
        rhs = 128'(rsum2) * 128'(len2);
        return lhs < rhs;
    endfunction

    function automatic logic [127:0] pack_query(query_t q);
        return {2'b00, q.capsule_radius, q.seg_end_y, q.seg_end_x, q.seg_start_y,
                q.seg_start_x, q.circle_radius, q.circle_y, q.circle_x};
    endfunction

    function automatic query_t make_query(int cx, int cy, int rc, int ax, int ay,
                                          int ex, int ey, int rk);
        query_t q;
        q.circle_x = COORD_W'(cx);
        q.circle_y = COORD_W'(cy);
        q.circle_radius = (COORD_W-1)'(rc);
        q.seg_start_x = COORD_W'(ax);
        q.seg_start_y = COORD_W'(ay);
        q.seg_end_x = COORD_W'(ex);
        q.seg_end_y = COORD_W'(ey);
        q.capsule_radius = (COORD_W-1)'(rk);
        return q;
    endfunction

    // Mostly short pauses, now and then a long one.
    function automatic int pick_pause();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    task automatic send_query(query_t q);
        int gap;
        gap = 0;
        if (tx_gaps && $urandom_range(0, 99) < 35) begin
            gap = pick_pause();
        end
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= {$urandom, $urandom, $urandom, $urandom};
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pack_query(q);
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
        pending_hits.push_back(predict_hit(q));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge aclk);
    endtask

    // Query with the segment and radii near the circle, so that hits and
    // misses both occur; a few segments have zero length or radii are zero.
    function automatic query_t nearby_query();
        query_t q;
        int span;
        case ($urandom_range(0, 3))
            0: span = 8;
            1: span = 64;
            2: span = 1024;
            default: span = 16384;
        endcase
        q.circle_x = COORD_W'($urandom);
        q.circle_y = COORD_W'($urandom);
        q.seg_start_x = COORD_W'(int'(q.circle_x) + $urandom_range(0, 2 * span) - span);
        q.seg_start_y = COORD_W'(int'(q.circle_y) + $urandom_range(0, 2 * span) - span);
        q.seg_end_x = COORD_W'(int'(q.circle_x) + $urandom_range(0, 2 * span) - span);
        q.seg_end_y = COORD_W'(int'(q.circle_y) + $urandom_range(0, 2 * span) - span);
        q.circle_radius = (COORD_W-1)'($urandom_range(0, span / 2));
        q.capsule_radius = (COORD_W-1)'($urandom_range(0, span / 2));
        if ($urandom_range(0, 11) == 0) begin
            q.seg_end_x = q.seg_start_x;
            q.seg_end_y = q.seg_start_y;
        end
        if ($urandom_range(0, 14) == 0) begin
            q.circle_radius = '0;
            q.capsule_radius = '0;
        end
        return q;
    endfunction

    function automatic query_t any_query();
        query_t q;
        q.circle_x = COORD_W'($urandom);
        q.circle_y = COORD_W'($urandom);
        q.circle_radius = (COORD_W-1)'($urandom);
        q.seg_start_x = COORD_W'($urandom);
        q.seg_start_y = COORD_W'($urandom);
        q.seg_end_x = COORD_W'($urandom);
        q.seg_end_y = COORD_W'($urandom);
        q.capsule_radius = (COORD_W-1)'($urandom);
        return q;
    endfunction

    task automatic test_directed_cases();
        // Everything zero: zero-length segment and both radii zero.
        send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0));
        // Centre on the segment but both radii zero: the strict test misses.
        send_query(make_query(50, 0, 0, 0, 0, 100, 0, 0));
        // Zero-length segment falls back to the start point.
        send_query(make_query(3, 4, 2, 0, 0, 0, 0, 4));
        send_query(make_query(3, 4, 2, 0, 0, 0, 0, 3));
        // Interior region, exactly touching then just overlapping.
        send_query(make_query(50, 10, 4, 0, 0, 100, 0, 6));
        send_query(make_query(50, 10, 4, 0, 0, 100, 0, 7));
        // Beyond the end point, touching and overlapping.
        send_query(make_query(110, 0, 5, 0, 0, 100, 0, 5));
        send_query(make_query(110, 0, 5, 0, 0, 100, 0, 6));
        // Before the start point, touching and overlapping.
        send_query(make_query(-10, 0, 5, 0, 0, 100, 0, 5));
        send_query(make_query(-10, 0, 5, 0, 0, 100, 0, 6));
        // Projection exactly at the end.
        send_query(make_query(100, 5, 2, 0, 0, 100, 0, 3));
        send_query(make_query(100, 5, 2, 0, 0, 100, 0, 4));
        // Coordinate and radius extremes.
        send_query(make_query(32767, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
        send_query(make_query(32767, -32768, 0, -32768, -32768, 32767, 32767, 0));
        send_query(make_query(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767));
        send_query(make_query(-32768, 32767, 1, 32767, -32768, -32768, 32767, 0));
        send_query(make_query(32767, 32767, 32767, 32767, 32767, -32768, -32768, 32767));
        send_query(make_query(-1, -1, 32767, -1, -1, -1, -1, 32767));
        send_query(make_query(0, 32767, 16000, -32768, 0, 32767, 0, 16767));
        send_query(make_query(0, 32767, 16000, -32768, 0, 32767, 0, 16768));
        wait_drained();
    endtask

    task automatic test_random_queries(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                tx_gaps = $urandom_range(0, 3) != 0;
                rx_stalls = $urandom_range(0, 3) != 0;
            end
            if ($urandom_range(0, 99) < 80) begin
                send_query(nearby_query());
            end else begin
                send_query(any_query());
            end
        end
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
    endtask

    task automatic test_full_rate(int count);
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        for (int i = 0; i < count; i++) begin
            send_query(nearby_query());
        end
        // Sender stays at full rate while the receiver stalls.
        rx_stalls = 1'b1;
        for (int i = 0; i < count / 2; i++) begin
            send_query(any_query());
        end
        tx_gaps = 1'b1;
    endtask

    task automatic test_drain_pause(int count);
        for (int i = 0; i < count; i++) begin
            send_query(nearby_query());
        end
        wait_drained();
        for (int i = 0; i < count; i++) begin
            send_query(nearby_query());
        end
    endtask

    // Result checker, receiver stalls and the no-progress watchdog.
    always @(posedge aclk) begin
        bit want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_hits.size() == 0) begin
                $error("result item with no query waiting: hit %0d", m_axis_tdata[0]);
                mismatch_count++;
            end else begin
                want = pending_hits.pop_front();
                if (m_axis_tdata[0] !== want) begin
                    $error("hit: expected %0d, actual %0d", want, m_axis_tdata[0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[7:1] !== 7'd0) begin
                    $error("tdata fill: expected 0, actual %0h", m_axis_tdata[7:1]);
                    mismatch_count++;
                end
            end
        end

        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end

        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_stalls && $urandom_range(0, 99) < 25) begin
            stall_left <= pick_pause() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_random_queries(980);
        test_full_rate(300);
        test_drain_pause(50);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/cct_pkg.sv
rtl/cct_geom.sv
rtl/cct_region.sv
rtl/cct_wide.sv
rtl/circle_capsule_overlap_test.sv
tb/sv/circle_capsule_overlap_test_tb.sv
